>>> src/cso_pkg.sv
// Shared widths, constants and types of the clock skew and offset estimator.
// No dependencies; imported by clock_skew_offset_estimator_core.
package cso_pkg;
    localparam int DEPTH    = 64;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int TIME_W   = 48;
    localparam int OFF_W    = 50;
    localparam int RATE_W   = 32;
    localparam int WL_W     = 32;
    localparam int LIMB     = 24;
    localparam int A_LIMBS  = 5;
    localparam int B_LIMBS  = 3;
    localparam int A_W      = LIMB * A_LIMBS;
    localparam int B_W      = LIMB * B_LIMBS;
    localparam int FRAC     = 30;

    localparam logic [RATE_W-1:0] RATE_ONE = 32'h4000_0000;
    localparam logic [RATE_W-1:0] RATE_MIN = 32'h2000_0000;
    localparam logic [RATE_W-1:0] RATE_MAX = 32'h8000_0000;
    localparam logic [WL_W-1:0]   WL_RESET = 32'd655360;

    typedef logic signed [127:0] t_w128;
endpackage

>>> src/clock_skew_offset_estimator_core.sv
// Clock skew and offset estimator: sequencer, pair store and one shared
// 24x24 multiply-accumulate unit. Depends on cso_pkg.
//
// Usage:
//  - Slave stream (s_axis_*): one item per time pair or query. tuser is the
//    kind (0 = sample, 1 = query); tdata carries local_time, session_time.
//  - Master stream (m_axis_*): one result item per input item carrying
//    session_offset, clock_rate and converted_time.
//  - Config channel (i_cfg_*): writes window_length; write only while idle.
//  - One item is worked at a time; s_axis_tready is high only when idle.
//  - Query: only the conversion runs. Sample: the pair is stored, old pairs
//    are pruned, and the offset pass checks every held pair, fitting only
//    those inside the last half window; when the rate is refit, the sums,
//    the normal sums and the division run first. The shared multiplier
//    works one 24-bit partial product at a time.
//  - The result is held in an output register until m_axis_tready; no new
//    item is taken while it waits. The core is ready on the next cycle.
//  - Reset (i_rst_n low, synchronous) empties the store, sets the rate to
//    1.0, the offset to zero and window_length to 655360. No clearing pass.
module clock_skew_offset_estimator_core
    import cso_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [95:0]       s_axis_tdata,   // local_time, session_time
    input  logic              s_axis_tuser,   // kind
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [135:0]      m_axis_tdata,   // session_offset, clock_rate, converted_time
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [WL_W-1:0]   i_cfg_data
);
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_SAMP    = 5'd1;
    localparam logic [4:0] S_PR_RD   = 5'd2;
    localparam logic [4:0] S_PR_CHK  = 5'd3;
    localparam logic [4:0] S_FIT_RD  = 5'd4;
    localparam logic [4:0] S_FIT_X   = 5'd5;
    localparam logic [4:0] S_FIT_XY  = 5'd6;
    localparam logic [4:0] S_FIT_NX  = 5'd7;
    localparam logic [4:0] S_DEN1    = 5'd8;
    localparam logic [4:0] S_NUM0    = 5'd9;
    localparam logic [4:0] S_NUM1    = 5'd10;
    localparam logic [4:0] S_DIV0    = 5'd11;
    localparam logic [4:0] S_DIV     = 5'd12;
    localparam logic [4:0] S_OFF_RD  = 5'd13;
    localparam logic [4:0] S_OFF_CHK = 5'd14;
    localparam logic [4:0] S_OFF_CMP = 5'd15;
    localparam logic [4:0] S_OFF_NX  = 5'd16;
    localparam logic [4:0] S_OFF_END = 5'd17;
    localparam logic [4:0] S_CONV    = 5'd18;
    localparam logic [4:0] S_CONV_END = 5'd19;
    localparam logic [4:0] S_OUT     = 5'd20;
    localparam logic [4:0] S_MUL     = 5'd21;
    localparam logic [4:0] S_DEN0    = 5'd22;
    localparam logic [4:0] S_DIV_END = 5'd23;

    localparam logic [2:0] D_SXX = 3'd0;
    localparam logic [2:0] D_SXY = 3'd1;
    localparam logic [2:0] D_DEN = 3'd2;
    localparam logic [2:0] D_NUM = 3'd3;
    localparam logic [2:0] D_VAL = 3'd4;

    logic [TIME_W-1:0] mem_l [DEPTH];
    logic [TIME_W-1:0] mem_s [DEPTH];

    logic [4:0]        r_state, r_ret;
    logic [AW-1:0]     r_oldest;
    logic [CW-1:0]     r_count, r_k;
    logic [RATE_W-1:0] r_rate;
    logic [OFF_W-1:0]  r_offset;
    logic [WL_W-1:0]   r_wl;
    logic [TIME_W-1:0] r_lt, r_st, r_rd_l, r_rd_s, r_ref_l, r_ref_s;
    logic [TIME_W-1:0] r_xm, r_ym;
    logic              r_xyneg;
    logic signed [54:0] r_sx, r_sy;
    t_w128             r_sxx, r_sxy, r_den, r_num, r_val, r_best, r_rem;
    logic              r_best_v;
    logic [RATE_W-1:0] r_q;
    logic [4:0]        r_dcnt;
    logic [A_W-1:0]    r_ma;
    logic [B_W-1:0]    r_mb;
    logic [2:0]        r_ia, r_na, r_psh, r_dst;
    logic [1:0]        r_ib, r_nb;
    logic              r_ph, r_sub;
    logic [2*LIMB-1:0] r_prod;
    logic [OFF_W-1:0]  r_o_off, r_o_conv;
    logic [RATE_W-1:0] r_o_rate;

    logic              full;
    logic [AW-1:0]     o1, wr_addr, rd_addr;
    logic [CW-1:0]     c1;
    logic [TIME_W:0]   d_c;
    logic signed [49:0] d50, wl50;
    logic signed [50:0] d51, wl51;
    logic [TIME_W:0]   x_c, y_c;
    logic [TIME_W-1:0] xm_c, ym_c;
    logic [LIMB-1:0]   limb_a, limb_b;
    t_w128             term, acc_sel, acc_new, rem2, conv_c;
    logic [54:0]       sxm, sym;
    logic [127:0]      sxym;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {4'b0, r_o_conv, r_o_rate, r_o_off};
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        full    = (r_count == CW'(DEPTH));
        o1      = full ? r_oldest + AW'(1) : r_oldest;
        c1      = full ? r_count - CW'(1) : r_count;
        wr_addr = o1 + c1[AW-1:0];
        rd_addr = r_oldest + r_k[AW-1:0];
        d_c     = {1'b0, r_lt} - {1'b0, r_rd_l};
        d50     = $signed({d_c[TIME_W], d_c});
        wl50    = $signed({18'b0, r_wl});
        d51     = $signed({d_c, 2'b0});
        wl51    = $signed({19'b0, r_wl});
        x_c     = {1'b0, r_rd_l} - {1'b0, r_ref_l};
        y_c     = {1'b0, r_rd_s} - {1'b0, r_ref_s};
        xm_c    = x_c[TIME_W] ? TIME_W'(-x_c) : x_c[TIME_W-1:0];
        ym_c    = y_c[TIME_W] ? TIME_W'(-y_c) : y_c[TIME_W-1:0];
        sxm     = r_sx[54] ? 55'(-r_sx) : 55'(r_sx);
        sym     = r_sy[54] ? 55'(-r_sy) : 55'(r_sy);
        sxym    = r_sxy[127] ? 128'(-r_sxy) : 128'(r_sxy);
        limb_a  = r_ma[r_ia*LIMB +: LIMB];
        limb_b  = r_mb[r_ib*LIMB +: LIMB];
        term    = t_w128'(r_prod) << (LIMB * r_psh);
        case (r_dst)
            D_SXX:   acc_sel = r_sxx;
            D_SXY:   acc_sel = r_sxy;
            D_DEN:   acc_sel = r_den;
            D_NUM:   acc_sel = r_num;
            default: acc_sel = r_val;
        endcase
        acc_new = r_sub ? acc_sel - term : acc_sel + term;
        rem2    = r_rem <<< 1;
        conv_c  = r_val >>> FRAC;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SAMP) begin
            mem_l[wr_addr] <= r_lt;
            mem_s[wr_addr] <= r_st;
        end
        r_rd_l <= mem_l[rd_addr];
        r_rd_s <= mem_s[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oldest <= '0;
            r_count  <= '0;
            r_rate   <= RATE_ONE;
            r_offset <= '0;
            r_wl     <= WL_RESET;
            r_k      <= '0;
            r_ph     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_wl <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_lt    <= s_axis_tdata[47:0];
                        r_st    <= s_axis_tdata[95:48];
                        r_k     <= '0;
                        r_state <= s_axis_tuser ? S_CONV : S_SAMP;
                    end
                end
                S_SAMP: begin
                    r_oldest <= o1;
                    r_count  <= c1 + CW'(1);
                    r_state  <= S_PR_RD;
                end
                S_PR_RD: r_state <= S_PR_CHK;
                S_PR_CHK: begin
                    if (r_count > CW'(2) && d50 > wl50) begin
                        r_oldest <= r_oldest + AW'(1);
                        r_count  <= r_count - CW'(1);
                        r_state  <= S_PR_RD;
                    end else if (r_count >= CW'(5) && d51 >= wl51) begin
                        r_ref_l <= r_rd_l;
                        r_ref_s <= r_rd_s;
                        r_sx    <= '0;
                        r_sy    <= '0;
                        r_sxx   <= '0;
                        r_sxy   <= '0;
                        r_state <= S_FIT_RD;
                    end else begin
                        r_best_v <= 1'b0;
                        r_state  <= S_OFF_RD;
                    end
                end
                S_FIT_RD: r_state <= S_FIT_X;
                S_FIT_X: begin
                    r_sx    <= r_sx + {{6{x_c[TIME_W]}}, x_c};
                    r_sy    <= r_sy + {{6{y_c[TIME_W]}}, y_c};
                    r_xm    <= xm_c;
                    r_ym    <= ym_c;
                    r_xyneg <= x_c[TIME_W] ^ y_c[TIME_W];
                    r_ma    <= A_W'(xm_c);
                    r_mb    <= B_W'(xm_c);
                    r_na    <= 3'd2;
                    r_nb    <= 2'd2;
                    r_sub   <= 1'b0;
                    r_dst   <= D_SXX;
                    r_ia    <= '0;
                    r_ib    <= '0;
                    r_ret   <= S_FIT_XY;
                    r_state <= S_MUL;
                end
                S_FIT_XY: begin
                    r_ma    <= A_W'(r_xm);
                    r_mb    <= B_W'(r_ym);
                    r_na    <= 3'd2;
                    r_nb    <= 2'd2;
                    r_sub   <= r_xyneg;
                    r_dst   <= D_SXY;
                    r_ia    <= '0;
                    r_ib    <= '0;
                    r_ret   <= S_FIT_NX;
                    r_state <= S_MUL;
                end
                S_FIT_NX: begin
                    if (r_k + CW'(1) == r_count) begin
                        r_k     <= '0;
                        r_state <= S_DEN0;
                    end else begin
                        r_k     <= r_k + CW'(1);
                        r_state <= S_FIT_RD;
                    end
                end
                S_DEN0: begin
                    r_den   <= '0;
                    r_num   <= '0;
                    r_ma    <= r_sxx[A_W-1:0];
                    r_mb    <= B_W'(r_count);
                    r_na    <= 3'd5;
                    r_nb    <= 2'd1;
                    r_sub   <= 1'b0;
                    r_dst   <= D_DEN;
                    r_ia    <= '0;
                    r_ib    <= '0;
                    r_ret   <= S_DEN1;
                    r_state <= S_MUL;
                end
                S_DEN1: begin
                    r_ma    <= A_W'(sxm);
                    r_mb    <= B_W'(sxm);
                    r_na    <= 3'd3;
                    r_nb    <= 2'd3;
                    r_sub   <= 1'b1;
                    r_dst   <= D_DEN;
                    r_ia    <= '0;
                    r_ib    <= '0;
                    r_ret   <= S_NUM0;
                    r_state <= S_MUL;
                end
                S_NUM0: begin
                    r_ma    <= sxym[A_W-1:0];
                    r_mb    <= B_W'(r_count);
                    r_na    <= 3'd5;
                    r_nb    <= 2'd1;
                    r_sub   <= r_sxy[127];
                    r_dst   <= D_NUM;
                    r_ia    <= '0;
                    r_ib    <= '0;
                    r_ret   <= S_NUM1;
                    r_state <= S_MUL;
                end
                S_NUM1: begin
                    r_ma    <= A_W'(sxm);
                    r_mb    <= B_W'(sym);
                    r_na    <= 3'd3;
                    r_nb    <= 2'd3;
                    r_sub   <= ~(r_sx[54] ^ r_sy[54]);
                    r_dst   <= D_NUM;
                    r_ia    <= '0;
                    r_ib    <= '0;
                    r_ret   <= S_DIV0;
                    r_state <= S_MUL;
                end
                S_DIV0: begin
                    r_best_v <= 1'b0;
                    if (r_den <= 0) begin
                        r_state <= S_OFF_RD;
                    end else if ((r_num <<< 1) <= r_den) begin
                        r_rate  <= RATE_MIN;
                        r_state <= S_OFF_RD;
                    end else if (r_num >= (r_den <<< 1)) begin
                        r_rate  <= RATE_MAX;
                        r_state <= S_OFF_RD;
                    end else begin
                        if (r_num >= r_den) begin
                            r_rem <= r_num - r_den;
                            r_q   <= RATE_W'(1);
                        end else begin
                            r_rem <= r_num;
                            r_q   <= '0;
                        end
                        r_dcnt  <= 5'(FRAC);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (rem2 >= r_den) begin
                        r_rem <= rem2 - r_den;
                        r_q   <= {r_q[RATE_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem2;
                        r_q   <= {r_q[RATE_W-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - 5'd1;
                    if (r_dcnt == 5'd1) begin
                        r_state <= S_DIV_END;
                    end
                end
                S_DIV_END: begin
                    r_rate  <= r_q;
                    r_state <= S_OFF_RD;
                end
                S_OFF_RD: r_state <= S_OFF_CHK;
                S_OFF_CHK: begin
                    if (d50 <= wl50 >>> 0 && $signed({d_c, 1'b0}) <= wl50) begin
                        r_val   <= {50'b0, r_rd_s, 30'b0};
                        r_ma    <= A_W'(r_rate);
                        r_mb    <= B_W'(r_rd_l);
                        r_na    <= 3'd2;
                        r_nb    <= 2'd2;
                        r_sub   <= 1'b1;
                        r_dst   <= D_VAL;
                        r_ia    <= '0;
                        r_ib    <= '0;
                        r_ret   <= S_OFF_CMP;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_OFF_NX;
                    end
                end
                S_OFF_CMP: begin
                    if (!r_best_v || r_val > r_best) begin
                        r_best <= r_val;
                    end
                    r_best_v <= 1'b1;
                    r_state  <= S_OFF_NX;
                end
                S_OFF_NX: begin
                    if (r_k + CW'(1) == r_count) begin
                        r_state <= S_OFF_END;
                    end else begin
                        r_k     <= r_k + CW'(1);
                        r_state <= S_OFF_RD;
                    end
                end
                S_OFF_END: begin
                    r_offset <= OFF_W'(r_best >>> FRAC);
                    r_state  <= S_CONV;
                end
                S_CONV: begin
                    r_val   <= {{48{r_offset[OFF_W-1]}}, r_offset, 30'b0};
                    r_ma    <= A_W'(r_rate);
                    r_mb    <= B_W'(r_lt);
                    r_na    <= 3'd2;
                    r_nb    <= 2'd2;
                    r_sub   <= 1'b0;
                    r_dst   <= D_VAL;
                    r_ia    <= '0;
                    r_ib    <= '0;
                    r_ret   <= S_CONV_END;
                    r_state <= S_MUL;
                end
                S_CONV_END: begin
                    r_o_off  <= r_offset;
                    r_o_rate <= r_rate;
                    if (conv_c > t_w128'(50'sh1_FFFF_FFFF_FFFF)) begin
                        r_o_conv <= 50'h1_FFFF_FFFF_FFFF;
                    end else if (conv_c < -(t_w128'(1) <<< 49)) begin
                        r_o_conv <= 50'h2_0000_0000_0000;
                    end else begin
                        r_o_conv <= conv_c[OFF_W-1:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_MUL: begin
                    if (!r_ph) begin
                        r_prod <= limb_a * limb_b;
                        r_psh  <= r_ia + {1'b0, r_ib};
                        r_ph   <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        case (r_dst)
                            D_SXX:   r_sxx <= acc_new;
                            D_SXY:   r_sxy <= acc_new;
                            D_DEN:   r_den <= acc_new;
                            D_NUM:   r_num <= acc_new;
                            default: r_val <= acc_new;
                        endcase
                        if (r_ib == r_nb - 2'd1) begin
                            r_ib <= '0;
                            if (r_ia == r_na - 3'd1) begin
                                r_state <= r_ret;
                            end else begin
                                r_ia <= r_ia + 3'd1;
                            end
                        end else begin
                            r_ib <= r_ib + 2'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("pair count above depth");
    a_rate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rate >= RATE_MIN && r_rate <= RATE_MAX) else $error("rate out of range");
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input open while result held");
    a_mul_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |-> (r_ia < r_na && r_ib < r_nb)) else $error("limb index overrun");
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for clock_skew_offset_estimator_core: stream driver,
// result monitor and a bit-exact, transaction-level estimator model with its own pair window.
// Depends on cso_pkg and the core RTL.
module tb_top;
    import cso_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;
    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef logic signed [191:0] t_w192;
    typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_SYNC} t_op;

    typedef struct {
        t_op               op;
        logic              kind;
        logic [TIME_W-1:0] lt;
        logic [TIME_W-1:0] st;
        logic [WL_W-1:0]   wl;
    } t_pending;

    typedef struct {
        logic [OFF_W-1:0]  offset;
        logic [RATE_W-1:0] rate;
        logic [OFF_W-1:0]  conv;
    } t_estimate;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [95:0]   s_axis_tdata = '0;   // local_time, session_time
    logic          s_axis_tuser = 1'b0; // kind
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [135:0]  m_axis_tdata;        // session_offset, clock_rate, converted_time
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [WL_W-1:0] i_cfg_data = '0;

    clock_skew_offset_estimator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    t_pending  pending_q[$];
    t_estimate estimate_q[$];
    longint    cycle_cnt = 0;
    int        mismatch_cnt = 0;
    int        result_cnt = 0;

    // estimator state
    logic [TIME_W-1:0] loc_mem[DEPTH];
    logic [TIME_W-1:0] ses_mem[DEPTH];
    int                head_slot = 0;
    int                held = 0;
    logic [RATE_W-1:0] rate_est = RATE_ONE;
    logic [OFF_W-1:0]  off_est = '0;
    logic [WL_W-1:0]   win_len = WL_RESET;

    function automatic t_w128 line_at(int i);
        return {50'b0, ses_mem[i], 30'b0} - t_w128'(rate_est) * t_w128'(loc_mem[i]);
    endfunction

    function automatic void refit_rate();
        longint sx = 0, sy = 0, x, y;
        t_w128  sxx = 0, sxy = 0, den, num;
        t_w192  q;
        int     i;
        for (int k = 0; k < held; k++) begin
            i = (head_slot + k) % DEPTH;
            x = longint'(loc_mem[i]) - longint'(loc_mem[head_slot]);
            y = longint'(ses_mem[i]) - longint'(ses_mem[head_slot]);
            sx += x;
            sy += y;
            sxx += t_w128'(x) * t_w128'(x);
            sxy += t_w128'(x) * t_w128'(y);
        end
        den = t_w128'(held) * sxx - t_w128'(sx) * t_w128'(sx);
        num = t_w128'(held) * sxy - t_w128'(sx) * t_w128'(sy);
        if (den <= 0) return;
        if ((num <<< 1) <= den) begin
            rate_est = RATE_MIN;
        end else if (num >= (den <<< 1)) begin
            rate_est = RATE_MAX;
        end else begin
            q = (t_w192'(num) <<< FRAC) / t_w192'(den);
            rate_est = q[RATE_W-1:0];
        end
    endfunction

    function automatic void add_pair(logic [TIME_W-1:0] lt, logic [TIME_W-1:0] st);
        int     back, i;
        longint span;
        t_w128  best, v;
        if (held >= DEPTH) begin
            head_slot = (head_slot + 1) % DEPTH;
            held--;
        end
        back = (head_slot + held) % DEPTH;
        loc_mem[back] = lt;
        ses_mem[back] = st;
        held++;
        while (held > 2 && longint'(lt) - longint'(loc_mem[head_slot]) > longint'(win_len)) begin
            head_slot = (head_slot + 1) % DEPTH;
            held--;
        end
        span = longint'(loc_mem[back]) - longint'(loc_mem[head_slot]);
        if (held >= 5 && span * 4 >= longint'(win_len)) refit_rate();
        best = line_at(back);
        for (int k = 0; k < held; k++) begin
            i = (head_slot + k) % DEPTH;
            if ((longint'(loc_mem[back]) - longint'(loc_mem[i])) * 2 <= longint'(win_len)) begin
                v = line_at(i);
                if (v > best) best = v;
            end
        end
        off_est = best[FRAC+OFF_W-1:FRAC];
    endfunction

    function automatic t_estimate estimate_item(t_pending it);
        t_estimate e;
        t_w128     v, c, lim;
        if (it.kind == KIND_SAMPLE) add_pair(it.lt, it.st);
        v = (t_w128'($signed(off_est)) <<< FRAC) + t_w128'(rate_est) * t_w128'(it.lt);
        c = v >>> FRAC;
        lim = t_w128'(1) <<< 49;
        if (c > lim - 1) c = lim - 1;
        if (c < -lim) c = -lim;
        e.offset = off_est;
        e.rate   = rate_est;
        e.conv   = c[OFF_W-1:0];
        return e;
    endfunction

    function automatic int pick_gap(logic quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    // driver
    int        drv_gap = 0;
    logic      took, cfg_took, busy;
    t_estimate est_new;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid   <= 1'b0;
            drv_gap = 0;
        end else begin
            took     = s_axis_tvalid && s_axis_tready;
            cfg_took = i_cfg_valid && o_cfg_ready;
            if (took) begin
                est_new = estimate_item(pending_q[0]);
                estimate_q.insert(estimate_q.size(), est_new);
                pending_q.delete(0);
            end
            if (cfg_took) begin
                win_len = i_cfg_data;
                pending_q.delete(0);
            end
            busy = (s_axis_tvalid && !took) || (i_cfg_valid && !cfg_took);
            if (!busy) begin
                if (drv_gap > 0 || pending_q.size() == 0) begin
                    if (drv_gap > 0) drv_gap--;
                    s_axis_tvalid <= 1'b0;
                    i_cfg_valid   <= 1'b0;
                end else begin
                    case (pending_q[0].op)
                        OP_ITEM: begin
                            s_axis_tdata  <= {pending_q[0].st, pending_q[0].lt};
                            s_axis_tuser  <= pending_q[0].kind;
                            s_axis_tvalid <= 1'b1;
                            i_cfg_valid   <= 1'b0;
                            drv_gap = pick_gap(((cycle_cnt / 4000) % 3) == 0);
                        end
                        OP_CFG: begin
                            s_axis_tvalid <= 1'b0;
                            if (estimate_q.size() == 0) begin
                                i_cfg_data  <= pending_q[0].wl;
                                i_cfg_valid <= 1'b1;
                            end else begin
                                i_cfg_valid <= 1'b0;
                            end
                        end
                        default: begin
                            s_axis_tvalid <= 1'b0;
                            i_cfg_valid   <= 1'b0;
                            if (estimate_q.size() == 0) pending_q.delete(0);
                        end
                    endcase
                end
            end
        end
    end

    // monitor
    int        hold_cnt = 0;
    logic      long_hold_done = 1'b0;
    t_estimate want;
    logic      bad;
    int        r_mon;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                result_cnt++;
                if (estimate_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result %h", m_axis_tdata);
                end else begin
                    want = estimate_q[0];
                    estimate_q.delete(0);
                    bad = m_axis_tdata[49:0] !== want.offset
                       || m_axis_tdata[81:50] !== want.rate
                       || m_axis_tdata[131:82] !== want.conv
                       || m_axis_tdata[135:132] !== 4'b0;
                    if (bad) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("result %0d: offset %h/%h rate %h/%h conv %h/%h (exp/act)",
                                     result_cnt, want.offset, m_axis_tdata[49:0],
                                     want.rate, m_axis_tdata[81:50],
                                     want.conv, m_axis_tdata[131:82]);
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else if (!long_hold_done && result_cnt >= 120) begin
                long_hold_done <= 1'b1;
                hold_cnt = 4000;
                m_axis_tready <= 1'b0;
            end else if (((cycle_cnt / 5000) % 3) == 1) begin
                m_axis_tready <= 1'b1;
            end else begin
                r_mon = $urandom_range(0, 99);
                if (r_mon < 8) hold_cnt = pick_gap(1'b0);
                m_axis_tready <= (r_mon >= 20);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic void push_item(logic kind, logic [TIME_W-1:0] lt, logic [TIME_W-1:0] st);
        t_pending p;
        p.op = OP_ITEM;
        p.kind = kind;
        p.lt = lt;
        p.st = st;
        p.wl = '0;
        pending_q.insert(pending_q.size(), p);
    endfunction

    function automatic void push_cfg(logic [WL_W-1:0] wl);
        t_pending p;
        p.op = OP_SYNC;
        pending_q.insert(pending_q.size(), p);
        p.op = OP_CFG;
        p.wl = wl;
        pending_q.insert(pending_q.size(), p);
    endfunction

    function automatic logic [TIME_W-1:0] rand48();
        return TIME_W'({$urandom(), $urandom()});
    endfunction

    // one clock track: local steps up, session follows slope with jitter; some items are queries
    function automatic void push_track(int n, logic [TIME_W-1:0] base_l,
                                       logic [TIME_W-1:0] base_s,
                                       int unsigned step_max, logic [31:0] slope);
        logic [TIME_W-1:0] cur_l = base_l;
        logic [127:0]      dl = 0, prod;
        logic [TIME_W-1:0] st;
        int unsigned       stp;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 30) begin
                push_item(KIND_QUERY, cur_l + $urandom_range(0, step_max), rand48());
            end else begin
                stp = $urandom_range(1, step_max);
                cur_l += stp;
                dl += stp;
                prod = (dl * slope) >> FRAC;
                st = base_s + prod[TIME_W-1:0] + $urandom_range(0, 6) - 3;
                push_item(KIND_SAMPLE, cur_l, st);
            end
        end
    endfunction

    function automatic int unsigned step_for(logic [WL_W-1:0] wl);
        logic [WL_W-1:0] s;
        s = wl / $urandom_range(4, 16);
        return (s == 0) ? 1 : s;
    endfunction

    logic [WL_W-1:0] wl_set[7] = '{32'd1, 32'hFFFF_FFFF, 32'd1000, 32'd655360,
                                   32'd40_000_000, 32'd2, 32'd123_457};
    int  cnt;

    initial begin
        // directed: extreme fields, clamps, time going backwards, saturation
        push_item(KIND_QUERY, '0, '0);
        push_item(KIND_QUERY, TIME_MAX, TIME_MAX);
        push_item(KIND_SAMPLE, '0, '0);
        push_item(KIND_SAMPLE, TIME_MAX, TIME_MAX);
        push_item(KIND_SAMPLE, 48'd100, 48'd50);
        push_track(7, 48'd1000, 48'd5000, 40000, 32'h1000_0000);
        push_track(7, 48'd900_000, 48'h8000_0000_0000, 40000, 32'hC000_0000);
        push_item(KIND_QUERY, TIME_MAX, '0);
        push_item(KIND_SAMPLE, TIME_MAX, '0);
        push_item(KIND_QUERY, '0, TIME_MAX);
        // random phases over window settings
        for (int ph = 0; ph < 7; ph++) begin
            if (ph > 0 && ph % 3 == 0) begin
                t_pending p;
                p.op = OP_SYNC;
                pending_q.insert(pending_q.size(), p);
            end
            push_cfg(wl_set[ph]);
            cnt = 0;
            while (cnt < 270) begin
                int n;
                if ($urandom_range(0, 99) < 80) begin
                    n = $urandom_range(5, (wl_set[ph] == 32'hFFFF_FFFF) ? 12 : 30);
                    push_track(n, rand48() >> $urandom_range(0, 2), rand48(),
                               step_for(wl_set[ph]),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(32'h1000_0000,
                               32'hA000_0000) : $urandom_range(32'h3F00_0000, 32'h4100_0000));
                end else begin
                    n = $urandom_range(1, 4);
                    for (int k = 0; k < n; k++)
                        push_item(1'($urandom_range(0, 1)), rand48(), rand48());
                end
                cnt += n;
            end
        end
        // full store: many pairs inside a wide window
        push_cfg(32'hFFFF_FFFF);
        push_track(80, 48'd10, 48'd20, 1000, 32'h4000_1000);
        push_cfg(32'd655360);
        push_track(20, 48'h7FFF_0000_0000, 48'd0, 60000, 32'h4000_0000);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_q.size() != 0 || estimate_q.size() != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
        if (mismatch_cnt == 0 && estimate_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
